// ----- rtl/core/sme_pkg.sv -----
// Package: shared types and constants for the stack machine executor.
`default_nettype none
package sme_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_PRINT = 4'd1,
    OP_READ  = 4'd2,
    OP_ADD   = 4'd3,
    OP_STOP  = 4'd4,
    OP_SUB   = 4'd5,
    OP_MUL   = 4'd6,
    OP_DIV   = 4'd7,
    OP_CMP   = 4'd8,
    OP_NEG   = 4'd9,
    OP_SWAP  = 4'd10,
    OP_POP   = 4'd11,
    OP_DUP   = 4'd12
  } op_e;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = 7;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [WordW-1:0] b;
    logic [WordW-1:0] a;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/sme_muldiv.sv -----
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
`default_nettype none
module sme_muldiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sme_pkg::alu_req_t req_i,
  output sme_pkg::alu_rsp_t      rsp_o
);
  import sme_pkg::*;

  logic             busy_q, busy_d;
  logic             div_q, div_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] acc_q, acc_d;   // product or remainder
  logic [WordW-1:0] sh_q, sh_d;     // multiplier bits or dividend/quotient
  logic [WordW-1:0] opa_q, opa_d;   // multiplicand or divisor magnitude
  logic             done_q, done_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rem_sh;
  logic [WordW-1:0] mb, ma;

  assign mb = req_i.b[WordW-1] ? (~req_i.b + 64'd1) : req_i.b;
  assign ma = req_i.a[WordW-1] ? (~req_i.a + 64'd1) : req_i.a;
  assign rem_sh = {acc_q[WordW-2:0], sh_q[WordW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, opa_q};

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    opa_d  = opa_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      div_d  = req_i.is_div;
      cnt_d  = '0;
      acc_d  = '0;
      if (req_i.is_div) begin
        sh_d  = mb;
        opa_d = ma;
        neg_d = req_i.b[WordW-1] ^ req_i.a[WordW-1];
      end else begin
        sh_d  = req_i.a;
        opa_d = req_i.b;
        neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (div_q) begin
        if (!trial[WordW]) begin
          acc_d = trial[WordW-1:0];
          sh_d  = {sh_q[WordW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          sh_d  = {sh_q[WordW-2:0], 1'b0};
        end
      end else begin
        // shift-add, LSB of multiplier first, product wraps to 64 bits
        if (sh_q[0]) acc_d = acc_q + (opa_q << cnt_q[5:0]);
        sh_d = {1'b0, sh_q[WordW-1:1]};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opa_q <= opa_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = div_q ? (neg_q ? (~sh_q + 64'd1) : sh_q) : acc_q;

  property p_no_done_while_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q;
  endproperty
  a_no_done_busy: assert property (p_no_done_while_busy) else $error("done while busy");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> cnt_q == '0) else $error("count not cleared");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("busy dropped without done");

endmodule
`default_nettype wire

// ----- rtl/core/stack_machine_executor.sv -----
// Top level: bytecode stack machine with sequencer, stack memory and shared mul/div.
//
//  channel | direction | signals
//  --------+-----------+---------------------------------------------------
//  in      | input     | in_valid_i / in_ready_o, mode_i, operand_i
//  out     | output    | out_valid_o / out_ready_i, print_valid_o,
//          |           | print_value_o, status_o, halted_o
//
// States from the accepting edge to out_valid_o: push/read/stop/pop, halted and
// unused codes S_DONE; print/add/sub/neg/dup, div by zero S_RDA, S_RDB, S_EXEC,
// S_DONE; swap adds S_WR2, cmp and mul/div S_WAIT (mul/div: 64 steps of the shared unit).
// Reset clears stack count, halt flag and the sequencer; stack data is not cleared.
// The result sits in an output register; the next item is taken after it transfers.
// in_ready_o is low while an item executes or while the held result is unread.
`default_nettype none
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  mode_i,
  input  wire logic signed [63:0] operand_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             print_valid_o,
  output logic signed [63:0] print_value_o,
  output logic [2:0]       status_o,
  output logic             halted_o
);
  import sme_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned NW = $clog2(STACK_DEPTH + 1);
  localparam logic [NW-1:0] Full = NW'(STACK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDA   = 7'b0000010,  // read top word
    S_RDB   = 7'b0000100,  // read word below
    S_EXEC  = 7'b0001000,
    S_WAIT  = 7'b0010000,  // mul/div running, or cmp result written
    S_WR2   = 7'b0100000,  // second write of swap
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // stack memory: one write port and one read port, registered read
  logic [WordW-1:0] mem [STACK_DEPTH];
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [WordW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [NW-1:0]    cnt_q, cnt_d;
  logic             halt_q, halt_d;
  op_e              op_q, op_d;
  logic [WordW-1:0] a_q, a_d, b_q, b_d;
  logic             ov_q, ov_d;
  logic             pv_q, pv_d;
  logic [WordW-1:0] pval_q, pval_d;
  logic [2:0]       st_q, st_d;
  logic             ho_q, ho_d;

  alu_req_t req;
  alu_rsp_t rsp;

  sme_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic [AW-1:0] top, below, next;
  assign top   = AW'(cnt_q - NW'(1));
  assign below = AW'(cnt_q - NW'(2));
  assign next  = AW'(cnt_q);

  logic             in_xfer;
  logic             sb, sa;
  logic [WordW-1:0] cmp_r;
  assign in_xfer = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;

  always_comb begin
    sb = b_q[WordW-1];
    sa = a_q[WordW-1];
    if ({~sb, b_q[WordW-2:0]} > {~sa, a_q[WordW-2:0]}) cmp_r = 64'd1;
    else if (b_q == a_q) cmp_r = '0;
    else cmp_r = '1;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    halt_d  = halt_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    ov_d    = ov_q;
    pv_d    = pv_q;
    pval_d  = pval_q;
    st_d    = st_q;
    ho_d    = ho_q;
    we      = 1'b0;
    waddr   = top;
    wdata   = a_q;
    raddr   = top;
    req     = '{start: 1'b0, is_div: (op_q == OP_DIV), b: b_q, a: a_q};

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d   = op_e'(mode_i);
          pv_d   = 1'b0;
          pval_d = '0;
          st_d   = ST_OK;
          state_d = S_DONE;
          if (halt_q) begin
            st_d = ST_HALT;
          end else begin
            case (mode_i)
              OP_PUSH, OP_READ: begin
                if (cnt_q >= Full) st_d = ST_OVER;
                else begin
                  we = 1'b1; waddr = next; wdata = operand_i;
                  cnt_d = cnt_q + NW'(1);
                end
              end
              OP_STOP: halt_d = 1'b1;
              OP_POP: begin
                if (cnt_q == '0) st_d = ST_UNDER;
                else cnt_d = cnt_q - NW'(1);
              end
              OP_PRINT, OP_NEG: begin
                if (cnt_q == '0) st_d = ST_UNDER;
                else state_d = S_RDA;
              end
              OP_DUP: begin
                if (cnt_q == '0) st_d = ST_UNDER;
                else if (cnt_q >= Full) st_d = ST_OVER;
                else state_d = S_RDA;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_SWAP: begin
                if (cnt_q < NW'(2)) st_d = ST_UNDER;
                else state_d = S_RDA;
              end
              default: ;
            endcase
          end
        end
      end
      S_RDA: begin
        a_d = rdata_q;  // top word
        raddr = below;
        state_d = S_RDB;
      end
      S_RDB: begin
        raddr = below;  // hold word below for S_EXEC
        state_d = S_EXEC;
        if (op_q == OP_PRINT || op_q == OP_NEG || op_q == OP_DUP)
          state_d = S_EXEC;
      end
      S_EXEC: begin
        b_d = rdata_q;
        state_d = S_DONE;
        case (op_q)
          OP_PRINT: begin
            pv_d = 1'b1; pval_d = a_q; cnt_d = cnt_q - NW'(1);
          end
          OP_NEG: begin
            we = 1'b1; waddr = top; wdata = ~a_q + 64'd1;
          end
          OP_DUP: begin
            we = 1'b1; waddr = next; wdata = a_q; cnt_d = cnt_q + NW'(1);
          end
          OP_ADD: begin
            we = 1'b1; waddr = below; wdata = rdata_q + a_q; cnt_d = cnt_q - NW'(1);
          end
          OP_SUB: begin
            we = 1'b1; waddr = below; wdata = rdata_q - a_q; cnt_d = cnt_q - NW'(1);
          end
          OP_SWAP: begin
            we = 1'b1; waddr = top; wdata = rdata_q; state_d = S_WR2;
          end
          OP_CMP, OP_MUL: state_d = S_WAIT;
          OP_DIV: begin
            if (a_q == '0) st_d = ST_DIV0;
            else state_d = S_WAIT;
          end
          default: ;
        endcase
      end
      S_WR2: begin
        we = 1'b1; waddr = below; wdata = a_q;
        state_d = S_DONE;
      end
      S_WAIT: begin
        if (op_q == OP_CMP) begin
          we = 1'b1; waddr = below; wdata = cmp_r; cnt_d = cnt_q - NW'(1);
          state_d = S_DONE;
        end else begin
          req.start = 1'b1;
          if (rsp.done) begin
            req.start = 1'b0;
            we = 1'b1; waddr = below; wdata = rsp.res; cnt_d = cnt_q - NW'(1);
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        ho_d = halt_q;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // start is held high in S_WAIT for mul/div; the unit ignores it while busy. When done
  // is seen, start is dropped and the state leaves S_WAIT, so no second run begins.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      halt_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      halt_q  <= halt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    pv_q   <= pv_d;
    pval_q <= pval_d;
    st_q   <= st_d;
    ho_q   <= ho_d;
  end

  assign out_valid_o   = ov_q;
  assign print_valid_o = pv_q;
  assign print_value_o = pval_q;
  assign status_o      = st_q;
  assign halted_o      = ho_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");

  a_cnt_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> $stable(cnt_q)) else $error("count moved after item");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");

endmodule
`default_nettype wire
